// File: src/bres_pkg.sv
// Shared types and constants for the Bresenham line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package bres_pkg;

	// Width of the pixel color carried through the block.
	localparam int unsigned COLOR_BITS = 24;

	// Item kinds on the command port.
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_STEP
	} bres_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic load;
		logic step;
	} bres_cmd_t;

endpackage

`default_nettype wire

// File: src/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasterizer.
//
// Command channel: a transaction is taken at a rising edge where start is
// high and busy is low. A transaction with kind 0 loads a new line (both
// endpoints and a color) and gives no result. A transaction with kind 1
// asks for the next pixel of the active line and gives exactly one result.
// Result channel: done is high for one cycle while pixel_x, pixel_y,
// pixel_color, last_pixel and no_line hold the result; the receiver must
// take it in that cycle, as it has no way to hold results off.
// Sequence: the accepting edge moves the controller out of idle, and the
// next edge runs the setup or the step arithmetic in the datapath on the
// line state and registers the result. done rises right after that edge,
// while busy is already low, so a new command can be taken in the cycle
// in which done is high; while busy is high no new command is taken.
// Reset: arst_n clears the controller and drops any active line; a step
// with no active line returns a result with no_line set.
`timescale 1ns / 1ps
`default_nettype none

module bresenham_line_rasterizer #(
	parameter int unsigned COORD_BITS = 12
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            kind,
	input  wire logic [COORD_BITS-1:0]           x_start,
	input  wire logic [COORD_BITS-1:0]           y_start,
	input  wire logic [COORD_BITS-1:0]           x_end,
	input  wire logic [COORD_BITS-1:0]           y_end,
	input  wire logic [bres_pkg::COLOR_BITS-1:0] line_color,
	output logic                                 done,
	output logic [COORD_BITS-1:0]                pixel_x,
	output logic [COORD_BITS-1:0]                pixel_y,
	output logic [bres_pkg::COLOR_BITS-1:0]      pixel_color,
	output logic                                 last_pixel,
	output logic                                 no_line
);
	import bres_pkg::*;

	bres_cmd_t cmd;

	// Sequencing of load and step transactions.
	bres_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Line state and pixel generation.
	bres_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.x_start     (x_start),
		.y_start     (y_start),
		.x_end       (x_end),
		.y_end       (y_end),
		.line_color  (line_color),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel),
		.no_line     (no_line),
		.done        (done)
	);

	// A step transaction yields its result once the step state has run.
	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_STEP) |=> ##1 done)
		else $error("step transaction produced no result");

	// A load transaction never yields a result.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_LOAD) |=> ##1 !done)
		else $error("load transaction produced a result");

	// A result only follows a busy cycle in which the step was worked out.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding step cycle");

	// The end of a line and the lack of a line exclude each other.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(last_pixel && no_line))
		else $error("last_pixel and no_line both set");

endmodule

`default_nettype wire

// File: src/bres_ctrl.sv
// Controller state machine for the Bresenham line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

module bres_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               kind,
	output bres_pkg::bres_cmd_t     cmd,
	output logic                    busy
);
	import bres_pkg::*;

	bres_state_t state_q;
	bres_state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_next  = state_q;
		cmd.capture = 1'b0;
		cmd.load    = 1'b0;
		cmd.step    = 1'b0;
		busy        = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_next  = (kind == KIND_STEP) ? ST_STEP : ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load   = 1'b1;
				state_next = ST_IDLE;
			end
			ST_STEP: begin
				cmd.step   = 1'b1;
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: src/bres_datapath.sv
// Datapath of the Bresenham line rasterizer: line state, setup and stepping.
`timescale 1ns / 1ps
`default_nettype none

module bres_datapath #(
	parameter int unsigned COORD_BITS = 12
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire bres_pkg::bres_cmd_t            cmd,
	input  wire logic [COORD_BITS-1:0]          x_start,
	input  wire logic [COORD_BITS-1:0]          y_start,
	input  wire logic [COORD_BITS-1:0]          x_end,
	input  wire logic [COORD_BITS-1:0]          y_end,
	input  wire logic [bres_pkg::COLOR_BITS-1:0] line_color,
	output logic [COORD_BITS-1:0]               pixel_x,
	output logic [COORD_BITS-1:0]               pixel_y,
	output logic [bres_pkg::COLOR_BITS-1:0]     pixel_color,
	output logic                                last_pixel,
	output logic                                no_line,
	output logic                                done
);
	import bres_pkg::*;

	localparam int unsigned DW = COORD_BITS + 1;
	localparam int unsigned EW = COORD_BITS + 3;

	// Captured load operands.
	logic [COORD_BITS-1:0] xs_q, ys_q, xe_q, ye_q;
	logic [COLOR_BITS-1:0] color_in_q;

	// Line state.
	logic [COORD_BITS-1:0] cur_x_q, cur_y_q, end_x_q, end_y_q;
	logic signed [EW-1:0]  err_q;
	logic [DW-1:0]         ddx_q, ddy_q;
	logic                  x_neg_q, y_neg_q, x_major_q;
	logic [COLOR_BITS-1:0] color_q;
	logic                  active_q;

	// Result registers.
	logic [COORD_BITS-1:0] pix_x_q, pix_y_q;
	logic [COLOR_BITS-1:0] pix_color_q;
	logic                  last_q, no_line_q, done_q;

	// Setup arithmetic on the captured endpoints.
	logic                  x_fwd, y_fwd;
	logic [COORD_BITS-1:0] adx, ady;
	logic [DW-1:0]         ddx_new, ddy_new;
	logic                  x_major_new;
	logic signed [EW-1:0]  err_new;

	always_comb begin
		x_fwd       = xe_q > xs_q;
		y_fwd       = ye_q > ys_q;
		adx         = x_fwd ? (xe_q - xs_q) : (xs_q - xe_q);
		ady         = y_fwd ? (ye_q - ys_q) : (ys_q - ye_q);
		ddx_new     = {adx, 1'b0};
		ddy_new     = {ady, 1'b0};
		x_major_new = adx > ady;
		err_new     = x_major_new ?
			($signed({2'b00, ddy_new}) - $signed({2'b00, ddx_new})) :
			($signed({2'b00, ddx_new}) - $signed({2'b00, ddy_new}));
	end

	// Stepping arithmetic on the line state.
	logic                  at_end, err_pos;
	logic [COORD_BITS-1:0] x_stepped, y_stepped;
	logic signed [EW-1:0]  ddx_ext, ddy_ext;

	always_comb begin
		at_end    = x_major_q ? (cur_x_q == end_x_q) : (cur_y_q == end_y_q);
		err_pos   = err_q > $signed(EW'(0));
		x_stepped = x_neg_q ? (cur_x_q - COORD_BITS'(1)) : (cur_x_q + COORD_BITS'(1));
		y_stepped = y_neg_q ? (cur_y_q - COORD_BITS'(1)) : (cur_y_q + COORD_BITS'(1));
		ddx_ext   = $signed({2'b00, ddx_q});
		ddy_ext   = $signed({2'b00, ddy_q});
	end

	// Operand capture at the accepting edge.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			xs_q       <= x_start;
			ys_q       <= y_start;
			xe_q       <= x_end;
			ye_q       <= y_end;
			color_in_q <= line_color;
		end
	end

	// Line state update for loads and steps.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_x_q   <= xs_q;
			cur_y_q   <= ys_q;
			end_x_q   <= xe_q;
			end_y_q   <= ye_q;
			color_q   <= color_in_q;
			x_neg_q   <= !x_fwd;
			y_neg_q   <= !y_fwd;
			ddx_q     <= ddx_new;
			ddy_q     <= ddy_new;
			x_major_q <= x_major_new;
			err_q     <= err_new;
		end else if (cmd.step && active_q && !at_end) begin
			if (x_major_q) begin
				cur_x_q <= x_stepped;
				if (err_pos) begin
					cur_y_q <= y_stepped;
					err_q   <= err_q + ddy_ext - ddx_ext;
				end else begin
					err_q   <= err_q + ddy_ext;
				end
			end else begin
				cur_y_q <= y_stepped;
				if (err_pos) begin
					cur_x_q <= x_stepped;
					err_q   <= err_q + ddx_ext - ddy_ext;
				end else begin
					err_q   <= err_q + ddx_ext;
				end
			end
		end
	end

	// Line active flag and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.step;
			if (cmd.load) begin
				active_q <= 1'b1;
			end else if (cmd.step && active_q && at_end) begin
				active_q <= 1'b0;
			end
		end
	end

	// Result payload for the step transaction.
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			if (!active_q) begin
				pix_x_q     <= '0;
				pix_y_q     <= '0;
				pix_color_q <= '0;
				last_q      <= 1'b0;
				no_line_q   <= 1'b1;
			end else if (at_end) begin
				pix_x_q     <= end_x_q;
				pix_y_q     <= end_y_q;
				pix_color_q <= color_q;
				last_q      <= 1'b1;
				no_line_q   <= 1'b0;
			end else begin
				pix_x_q     <= cur_x_q;
				pix_y_q     <= cur_y_q;
				pix_color_q <= color_q;
				last_q      <= 1'b0;
				no_line_q   <= 1'b0;
			end
		end
	end

	assign pixel_x     = pix_x_q;
	assign pixel_y     = pix_y_q;
	assign pixel_color = pix_color_q;
	assign last_pixel  = last_q;
	assign no_line     = no_line_q;
	assign done        = done_q;

endmodule

`default_nettype wire

// File: test/bresenham_line_rasterizer_tb.sv
// Self-checking testbench for the Bresenham line rasterizer: directed table, then random lines.
`timescale 1ns / 1ps

module bresenham_line_rasterizer_tb;
	import bres_pkg::*;

	localparam int unsigned CB = 12;
	localparam int unsigned RANDOM_ITEMS = 500;
	localparam int unsigned CYCLE_LIMIT = 200000;

	// One command transaction as it appears on the input ports.
	typedef struct packed {
		logic                  kind;
		logic [CB-1:0]         xs;
		logic [CB-1:0]         ys;
		logic [CB-1:0]         xe;
		logic [CB-1:0]         ye;
		logic [COLOR_BITS-1:0] color;
	} command_t;

	// One emitted pixel as it appears on the result ports.
	typedef struct packed {
		logic [CB-1:0]         x;
		logic [CB-1:0]         y;
		logic [COLOR_BITS-1:0] color;
		logic                  last;
		logic                  nol;
	} pixel_t;

	// A row of the directed table; the pixel is used only when typed is set.
	typedef struct packed {
		command_t cmd;
		logic     typed;
		pixel_t   want;
	} table_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  kind;
	logic [CB-1:0]         x_start;
	logic [CB-1:0]         y_start;
	logic [CB-1:0]         x_end;
	logic [CB-1:0]         y_end;
	logic [COLOR_BITS-1:0] line_color;
	logic                  done;
	logic [CB-1:0]         pixel_x;
	logic [CB-1:0]         pixel_y;
	logic [COLOR_BITS-1:0] pixel_color;
	logic                  last_pixel;
	logic                  no_line;

	// Line state mirrored from the block.
	logic [CB-1:0]         trk_x;
	logic [CB-1:0]         trk_y;
	logic [CB-1:0]         trk_end_x;
	logic [CB-1:0]         trk_end_y;
	logic signed [CB+2:0]  trk_err;
	logic [CB:0]           trk_ddx;
	logic [CB:0]           trk_ddy;
	logic                  trk_xneg;
	logic                  trk_yneg;
	logic                  trk_xmajor;
	logic [COLOR_BITS-1:0] trk_color;
	logic                  trk_active;

	pixel_t     pending_pixels[$];
	table_row_t directed_rows[$];
	int         error_count;
	int         issued;
	int         cycle_count;
	logic       no_idle;

	bresenham_line_rasterizer #(
		.COORD_BITS(CB)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.line_color (line_color),
		.done       (done),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_color(pixel_color),
		.last_pixel (last_pixel),
		.no_line    (no_line)
	);

	always #5 clk = ~clk;

	// Works out the pixel, if any, that one command produces and advances the line state.
	task automatic trace_line(input command_t c, output logic has, output pixel_t px);
		logic signed [CB:0] dx;
		logic signed [CB:0] dy;
		logic [CB:0]        adx;
		logic [CB:0]        ady;
		has = 1'b0;
		px = '0;
		if (c.kind == KIND_LOAD) begin
			dx = $signed({1'b0, c.xe}) - $signed({1'b0, c.xs});
			dy = $signed({1'b0, c.ye}) - $signed({1'b0, c.ys});
			adx = dx[CB] ? -dx : dx;
			ady = dy[CB] ? -dy : dy;
			trk_x = c.xs;
			trk_y = c.ys;
			trk_end_x = c.xe;
			trk_end_y = c.ye;
			trk_color = c.color;
			trk_xneg = !(dx > 0);
			trk_yneg = !(dy > 0);
			trk_ddx = adx << 1;
			trk_ddy = ady << 1;
			trk_xmajor = adx > ady;
			if (trk_xmajor) begin
				trk_err = $signed({2'b00, trk_ddy}) - $signed({2'b00, trk_ddx});
			end else begin
				trk_err = $signed({2'b00, trk_ddx}) - $signed({2'b00, trk_ddy});
			end
			trk_active = 1'b1;
		end else if (!trk_active) begin
			has = 1'b1;
			px.nol = 1'b1;
		end else if (trk_xmajor ? (trk_x == trk_end_x) : (trk_y == trk_end_y)) begin
			// The major axis has arrived: give the end point and close the line.
			has = 1'b1;
			px = '{trk_end_x, trk_end_y, trk_color, 1'b1, 1'b0};
			trk_active = 1'b0;
		end else begin
			has = 1'b1;
			px = '{trk_x, trk_y, trk_color, 1'b0, 1'b0};
			if (trk_xmajor) begin
				if (trk_err > 0) begin
					trk_y = trk_yneg ? trk_y - 1'b1 : trk_y + 1'b1;
					trk_err = trk_err + $signed({2'b00, trk_ddy}) - $signed({2'b00, trk_ddx});
				end else begin
					trk_err = trk_err + $signed({2'b00, trk_ddy});
				end
				trk_x = trk_xneg ? trk_x - 1'b1 : trk_x + 1'b1;
			end else begin
				if (trk_err > 0) begin
					trk_x = trk_xneg ? trk_x - 1'b1 : trk_x + 1'b1;
					trk_err = trk_err + $signed({2'b00, trk_ddx}) - $signed({2'b00, trk_ddy});
				end else begin
					trk_err = trk_err + $signed({2'b00, trk_ddx});
				end
				trk_y = trk_yneg ? trk_y - 1'b1 : trk_y + 1'b1;
			end
		end
	endtask

	// Drives one command, waits for the transaction and queues its expected pixel, if it has one.
	task automatic send_command(input command_t c, input logic typed, input pixel_t want);
		int     gap;
		logic   has;
		pixel_t got;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= c.kind;
		x_start <= c.xs;
		y_start <= c.ys;
		x_end <= c.xe;
		y_end <= c.ye;
		line_color <= c.color;
		@(posedge clk);
		while (busy) @(posedge clk);
		trace_line(c, has, got);
		if (has) begin
			pending_pixels.push_back(typed ? want : got);
		end
		issued++;
	endtask

	task automatic add_row(input logic k, input int xs, input int ys, input int xe, input int ye,
			input int color, input logic typed, input pixel_t want);
		table_row_t r;
		r.cmd = '{k, CB'(xs), CB'(ys), CB'(xe), CB'(ye), COLOR_BITS'(color)};
		r.typed = typed;
		r.want = want;
		directed_rows.push_back(r);
	endtask

	// A step command with random contents in the ignored fields.
	function automatic command_t random_step();
		command_t c;
		c = '{KIND_STEP, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
			COLOR_BITS'($urandom)};
		return c;
	endfunction

	// Number of step commands that give the pixels of a loaded line, end point included.
	function automatic int line_length(input command_t c);
		int adx;
		int ady;
		adx = int'(c.xe) - int'(c.xs);
		ady = int'(c.ye) - int'(c.ys);
		if (adx < 0) adx = -adx;
		if (ady < 0) ady = -ady;
		return ((adx > ady) ? adx : ady) + 1;
	endfunction

	// Picks a coordinate, now and then at either end of the range.
	function automatic logic [CB-1:0] random_coord();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return CB'($urandom);
		endcase
	endfunction

	// Each result cycle is compared with the oldest queued pixel.
	always @(posedge clk) begin
		pixel_t got;
		pixel_t want;
		if (arst_n && done) begin
			got = '{pixel_x, pixel_y, pixel_color, last_pixel, no_line};
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b no_line=%b",
					$time, got.x, got.y, got.color, got.last, got.nol);
				error_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (got !== want) begin
					$display("%0t: pixel mismatch expected x=%0d y=%0d color=%h last=%b no_line=%b",
						$time, want.x, want.y, want.color, want.last, want.nol);
					$display("%0t:                  actual x=%0d y=%0d color=%h last=%b no_line=%b",
						$time, got.x, got.y, got.color, got.last, got.nol);
					error_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		pixel_t   none;
		pixel_t   empty;
		command_t c;
		int       n;
		int       len;
		int       off;
		logic     paused;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_LOAD;
		x_start = '0;
		y_start = '0;
		x_end = '0;
		y_end = '0;
		line_color = '0;
		error_count = 0;
		issued = 0;
		cycle_count = 0;
		no_idle = 1'b0;
		paused = 1'b0;
		none = '0;
		empty = '0;
		empty.nol = 1'b1;
		trace_line('0, paused, none);
		trk_active = 1'b0;
		trk_x = '0;
		trk_y = '0;
		none = '0;
		paused = 1'b0;

		// Directed table: empty steps, single-point lines, extremes, a load during a line,
		// a diagonal tie and lines in several octants.
		add_row(KIND_STEP, 0, 0, 0, 0, 0, 1'b1, empty);
		add_row(KIND_LOAD, 0, 0, 0, 0, 'hFFFFFF, 1'b0, none);
		add_row(KIND_STEP, 4095, 4095, 4095, 4095, 'hFFFFFF, 1'b1,
			'{12'd0, 12'd0, 24'hFFFFFF, 1'b1, 1'b0});
		add_row(KIND_STEP, 0, 0, 0, 0, 0, 1'b1, empty);
		add_row(KIND_LOAD, 4095, 4095, 4095, 4095, 0, 1'b0, none);
		add_row(KIND_STEP, 0, 0, 0, 0, 0, 1'b1, '{12'd4095, 12'd4095, 24'h000000, 1'b1, 1'b0});
		add_row(KIND_LOAD, 0, 0, 4095, 0, 'h123456, 1'b0, none);
		add_row(KIND_STEP, 0, 0, 0, 0, 0, 1'b1, '{12'd0, 12'd0, 24'h123456, 1'b0, 1'b0});
		add_row(KIND_STEP, 0, 0, 0, 0, 0, 1'b0, none);
		add_row(KIND_STEP, 0, 0, 0, 0, 0, 1'b0, none);
		add_row(KIND_LOAD, 4095, 0, 0, 4095, 'hABCDEF, 1'b0, none);
		add_row(KIND_STEP, 0, 0, 0, 0, 0, 1'b1, '{12'd4095, 12'd0, 24'hABCDEF, 1'b0, 1'b0});
		add_row(KIND_STEP, 0, 0, 0, 0, 0, 1'b0, none);
		add_row(KIND_LOAD, 10, 20, 7, 30, 'h00FF00, 1'b0, none);
		for (int i = 0; i < 4; i++) add_row(KIND_STEP, 0, 0, 0, 0, 0, 1'b0, none);
		add_row(KIND_LOAD, 100, 50, 90, 50, 'h800001, 1'b0, none);
		for (int i = 0; i < 2; i++) add_row(KIND_STEP, 0, 0, 0, 0, 0, 1'b0, none);
		add_row(KIND_LOAD, 2, 9, 2, 5, 'h0F0F0F, 1'b0, none);
		for (int i = 0; i < 3; i++) add_row(KIND_STEP, 0, 0, 0, 0, 0, 1'b0, none);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
		end

		// Hold the sender until every pixel so far has come back.
		start <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);

		// Random lines, mostly short and run to their end; some cut off, overrun or long.
		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			if (!paused && issued >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				start <= 1'b0;
				@(posedge clk);
				while (pending_pixels.size() != 0) @(posedge clk);
			end
			if ($urandom_range(0, 3) == 0) no_idle = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 9) == 0) begin
				send_command(random_step(), 1'b0, none);
			end else begin
				c.kind = KIND_LOAD;
				c.xs = random_coord();
				c.ys = random_coord();
				c.color = COLOR_BITS'($urandom);
				if ($urandom_range(0, 7) == 0) begin
					c.xe = random_coord();
					c.ye = random_coord();
				end else begin
					off = $urandom_range(0, 32) - 16;
					c.xe = c.xs + CB'(off);
					off = $urandom_range(0, 32) - 16;
					c.ye = c.ys + CB'(off);
				end
				len = line_length(c);
				send_command(c, 1'b0, none);
				case ($urandom_range(0, 5))
					0: n = $urandom_range(0, len);
					1: n = len + $urandom_range(1, 2);
					default: n = len;
				endcase
				if (n > 64) n = $urandom_range(1, 64);
				repeat (n) send_command(random_step(), 1'b0, none);
			end
		end
		start <= 1'b0;

		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		if (error_count == 0 && pending_pixels.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
